// ----- design/ecal_pkg.sv -----
package ecal_pkg;

   // widths of the result fields
   localparam int YEAR_W   = 12;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;

   // default width of the seconds count
   localparam int SECONDS_BITS_DEFAULT = 32;

   // time of day divisors
   localparam int SECS_PER_DAY  = 86400;
   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_MIN  = 60;

   // width of the time of day, holds anything below one day
   localparam int REM_BITS = $clog2(SECS_PER_DAY);

   // fixed-point reciprocal, rounded up, for exact division by a constant
   function automatic longint unsigned recip(int shift, int divisor);
      longint unsigned num;
      num = (64'd1 << shift) + 64'(divisor - 1);
      return num / 64'(divisor);
   endfunction

   // day split: 86400 is 2**7 times 675
   localparam int DAY_POW2    = 7;
   localparam int DAY_ODD     = SECS_PER_DAY >> DAY_POW2;
   localparam int DAY_ODD_LOG = $clog2(DAY_ODD);

   // hour split of the time of day: 3600 is 2**4 times 225
   localparam int HOUR_POW2  = 4;
   localparam int HOUR_ODD   = SECS_PER_HOUR >> HOUR_POW2;
   localparam int HQ_BITS    = REM_BITS - HOUR_POW2;
   localparam int HOUR_SHIFT = HQ_BITS + $clog2(HOUR_ODD);
   localparam longint unsigned HOUR_RECIP = recip(HOUR_SHIFT, HOUR_ODD);

   // minute split of what is left of the hour: 60 is 2**2 times 15
   localparam int MREM_BITS = $clog2(SECS_PER_HOUR);
   localparam int MIN_POW2  = 2;
   localparam int MIN_ODD   = SECS_PER_MIN >> MIN_POW2;
   localparam int MQ_BITS   = MREM_BITS - MIN_POW2;
   localparam int MIN_SHIFT = MQ_BITS + $clog2(MIN_ODD);
   localparam longint unsigned MIN_RECIP = recip(MIN_SHIFT, MIN_ODD);

   // calendar constants
   localparam int EPOCH_YEAR    = 1970;
   localparam int DAYS_PER_YEAR = 365;
   localparam int YLEN_W        = $clog2(DAYS_PER_YEAR + 2);

   // leap rule counters: year mod 4, mod 100 and mod 400
   localparam int C4_W      = $clog2(4);
   localparam int C100_W    = $clog2(100);
   localparam int C400_W    = $clog2(400);
   localparam int C4_LAST   = 4 - 1;
   localparam int C100_LAST = 100 - 1;
   localparam int C400_LAST = 400 - 1;
   localparam int C4_START   = EPOCH_YEAR % 4;
   localparam int C100_START = EPOCH_YEAR % 100;
   localparam int C400_START = EPOCH_YEAR % 400;

   // month index, 0 is january
   localparam int MONTH_IDX_W = 4;
   localparam logic [MONTH_IDX_W-1:0] MONTH_FEB = MONTH_IDX_W'(1);
   localparam logic [MONTH_IDX_W-1:0] MONTH_DEC = MONTH_IDX_W'(11);

   // month lengths of a common year
   localparam logic [DAY_W-1:0] MONTH_DAYS [12] = '{
      DAY_W'(31), DAY_W'(28), DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30),
      DAY_W'(31), DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30), DAY_W'(31)
   };

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // time of day as handed from front to back
   typedef struct packed {
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
   } tod_type;

   // day count width: the divisor is above 2**(REM_BITS-1)
   function automatic int day_bits(int seconds_bits);
      return seconds_bits - REM_BITS + 1;
   endfunction

   // full year width, never below the result field
   function automatic int year_bits(int seconds_bits);
      int d;
      int w;
      d = day_bits(seconds_bits);
      w = $clog2(EPOCH_YEAR + 2 ** (d - $clog2(DAYS_PER_YEAR) + 1));
      return (w > YEAR_W) ? w : YEAR_W;
   endfunction

endpackage

// ----- design/ecal_if.sv -----
interface ecal_req_if #(
   parameter int SECONDS_BITS = ecal_pkg::SECONDS_BITS_DEFAULT
);
   logic                    valid;
   logic                    ready;
   logic [SECONDS_BITS-1:0] epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ecal_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ecal_pkg::YEAR_W-1:0]   year;
   logic [ecal_pkg::MONTH_W-1:0]  month;
   logic [ecal_pkg::DAY_W-1:0]    day_of_month;
   logic [ecal_pkg::HOUR_W-1:0]   hour;
   logic [ecal_pkg::MINUTE_W-1:0] minute;
   logic [ecal_pkg::SECOND_W-1:0] second;

   modport source (
      output valid, output year, output month, output day_of_month,
      output hour, output minute, output second, input ready
   );
   modport sink (
      input valid, input year, input month, input day_of_month,
      input hour, input minute, input second, output ready
   );
endinterface

// ----- design/ecal_front.sv -----
module ecal_front #(
   parameter int SECONDS_BITS = ecal_pkg::SECONDS_BITS_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   ecal_req_if.sink                                      req_ch,
   output logic                                          push_valid,
   input  logic                                          push_ready,
   output logic [ecal_pkg::day_bits(SECONDS_BITS)-1:0]   push_days,
   output ecal_pkg::tod_type                             push_tod
);

   localparam int DAY_BITS   = ecal_pkg::day_bits(SECONDS_BITS);
   localparam int REM_BITS   = ecal_pkg::REM_BITS;
   localparam int Q1_BITS    = SECONDS_BITS - ecal_pkg::DAY_POW2;
   localparam int DAY_SHIFT  = Q1_BITS + ecal_pkg::DAY_ODD_LOG;
   localparam longint unsigned DAY_RECIP = ecal_pkg::recip(DAY_SHIFT, ecal_pkg::DAY_ODD);
   localparam int RECIP_BITS = Q1_BITS + 1;
   localparam int LO_BITS    = RECIP_BITS / 2;
   localparam int HI_BITS    = RECIP_BITS - LO_BITS;
   localparam int PLO_BITS   = Q1_BITS + LO_BITS;
   localparam int PHI_BITS   = Q1_BITS + HI_BITS;
   localparam int PROD_BITS  = Q1_BITS + RECIP_BITS;
   localparam int HPROD_BITS = 2 * ecal_pkg::HQ_BITS + 1;
   localparam int MPROD_BITS = 2 * ecal_pkg::MQ_BITS + 1;
   localparam logic [LO_BITS-1:0] RECIP_LO = LO_BITS'(DAY_RECIP);
   localparam logic [HI_BITS-1:0] RECIP_HI = HI_BITS'(DAY_RECIP >> LO_BITS);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_DAY, ST_TOD, ST_HOUR, ST_HREM, ST_MIN, ST_SEC, ST_PUSH
   } state_type;

   state_type               state_ff, state_in;
   logic [SECONDS_BITS-1:0] num_ff, num_in;
   logic [PLO_BITS-1:0]     plo_ff, plo_in;
   logic [PHI_BITS-1:0]     phi_ff, phi_in;
   logic [DAY_BITS-1:0]     days_ff, days_in;
   logic [REM_BITS-1:0]     rem_ff, rem_in;
   ecal_pkg::tod_type       tod_ff, tod_in;

   logic [Q1_BITS-1:0]      q1;
   logic [PROD_BITS-1:0]    prod;
   logic [HPROD_BITS-1:0]   hour_prod;
   logic [MPROD_BITS-1:0]   min_prod;

   // seconds over 128, then times the reciprocal of 675 in two halves
   assign q1   = num_ff[SECONDS_BITS-1:ecal_pkg::DAY_POW2];
   assign prod = PROD_BITS'(plo_ff) + {phi_ff, {LO_BITS{1'b0}}};

   // hours and minutes by reciprocal of the odd part of the divisor
   assign hour_prod = HPROD_BITS'(rem_ff[REM_BITS-1:ecal_pkg::HOUR_POW2])
                    * HPROD_BITS'(ecal_pkg::HOUR_RECIP);
   assign min_prod  = MPROD_BITS'(rem_ff[ecal_pkg::MREM_BITS-1:ecal_pkg::MIN_POW2])
                    * MPROD_BITS'(ecal_pkg::MIN_RECIP);

   // sequencer, one arithmetic step per state
   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      plo_in   = plo_ff;
      phi_in   = phi_ff;
      days_in  = days_ff;
      rem_in   = rem_ff;
      tod_in   = tod_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               num_in   = req_ch.epoch_seconds;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            plo_in   = PLO_BITS'(q1) * PLO_BITS'(RECIP_LO);
            phi_in   = PHI_BITS'(q1) * PHI_BITS'(RECIP_HI);
            state_in = ST_DAY;
         end
         ST_DAY: begin
            days_in  = DAY_BITS'(prod >> DAY_SHIFT);
            state_in = ST_TOD;
         end
         ST_TOD: begin
            // time of day is below one day, so the low bits suffice
            rem_in   = REM_BITS'(num_ff - SECONDS_BITS'(days_ff)
                                 * SECONDS_BITS'(ecal_pkg::SECS_PER_DAY));
            state_in = ST_HOUR;
         end
         ST_HOUR: begin
            tod_in.hour = ecal_pkg::HOUR_W'(hour_prod >> ecal_pkg::HOUR_SHIFT);
            state_in    = ST_HREM;
         end
         ST_HREM: begin
            rem_in   = rem_ff - REM_BITS'(tod_ff.hour) * REM_BITS'(ecal_pkg::SECS_PER_HOUR);
            state_in = ST_MIN;
         end
         ST_MIN: begin
            tod_in.minute = ecal_pkg::MINUTE_W'(min_prod >> ecal_pkg::MIN_SHIFT);
            state_in      = ST_SEC;
         end
         ST_SEC: begin
            tod_in.second = ecal_pkg::SECOND_W'(rem_ff - REM_BITS'(tod_ff.minute)
                                                * REM_BITS'(ecal_pkg::SECS_PER_MIN));
            state_in      = ST_PUSH;
         end
         ST_PUSH: begin
            if (push_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      num_ff  <= num_in;
      plo_ff  <= plo_in;
      phi_ff  <= phi_in;
      days_ff <= days_in;
      rem_ff  <= rem_in;
      tod_ff  <= tod_in;
   end

   assign req_ch.ready = state_ff == ST_IDLE;
   assign push_valid   = state_ff == ST_PUSH;
   assign push_days    = days_ff;
   assign push_tod     = tod_ff;

endmodule

// ----- design/ecal_fifo.sv -----
module ecal_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = ecal_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign push_ready = count_ff != CNT_BITS'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- design/ecal_back.sv -----
module ecal_back #(
   parameter int SECONDS_BITS = ecal_pkg::SECONDS_BITS_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          pop_valid,
   output logic                                          pop_ready,
   input  logic [ecal_pkg::day_bits(SECONDS_BITS)-1:0]   pop_days,
   input  ecal_pkg::tod_type                             pop_tod,
   ecal_rsp_if.source                                    rsp_ch
);

   localparam int DAY_BITS  = ecal_pkg::day_bits(SECONDS_BITS);
   localparam int YEAR_BITS = ecal_pkg::year_bits(SECONDS_BITS);

   typedef enum logic [1:0] {ST_IDLE, ST_YEAR, ST_MONTH, ST_OUT} state_type;

   state_type                            state_ff, state_in;
   logic [DAY_BITS-1:0]                  days_ff, days_in;
   logic [YEAR_BITS-1:0]                 year_ff, year_in;
   logic [ecal_pkg::C4_W-1:0]            c4_ff, c4_in;
   logic [ecal_pkg::C100_W-1:0]          c100_ff, c100_in;
   logic [ecal_pkg::C400_W-1:0]          c400_ff, c400_in;
   logic [ecal_pkg::MONTH_IDX_W-1:0]     month_ff, month_in;
   ecal_pkg::tod_type                    tod_ff, tod_in;
   logic [ecal_pkg::YEAR_W-1:0]          out_year_ff, out_year_in;
   logic [ecal_pkg::MONTH_W-1:0]         out_month_ff, out_month_in;
   logic [ecal_pkg::DAY_W-1:0]           out_dom_ff, out_dom_in;
   ecal_pkg::tod_type                    out_tod_ff, out_tod_in;

   logic                                 leap;
   logic [ecal_pkg::YLEN_W-1:0]          ylen;
   logic [ecal_pkg::DAY_W-1:0]           mlen;

   // gregorian leap rule from the modulo counters
   assign leap = (c400_ff == '0) || ((c100_ff != '0) && (c4_ff == '0));
   assign ylen = leap ? ecal_pkg::YLEN_W'(ecal_pkg::DAYS_PER_YEAR + 1)
                      : ecal_pkg::YLEN_W'(ecal_pkg::DAYS_PER_YEAR);
   assign mlen = ecal_pkg::MONTH_DAYS[month_ff]
               + ecal_pkg::DAY_W'((month_ff == ecal_pkg::MONTH_FEB) && leap);

   // year then month subtraction, one step a cycle
   always_comb begin
      state_in     = state_ff;
      days_in      = days_ff;
      year_in      = year_ff;
      c4_in        = c4_ff;
      c100_in      = c100_ff;
      c400_in      = c400_ff;
      month_in     = month_ff;
      tod_in       = tod_ff;
      out_year_in  = out_year_ff;
      out_month_in = out_month_ff;
      out_dom_in   = out_dom_ff;
      out_tod_in   = out_tod_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               days_in  = pop_days;
               tod_in   = pop_tod;
               year_in  = YEAR_BITS'(ecal_pkg::EPOCH_YEAR);
               c4_in    = ecal_pkg::C4_W'(ecal_pkg::C4_START);
               c100_in  = ecal_pkg::C100_W'(ecal_pkg::C100_START);
               c400_in  = ecal_pkg::C400_W'(ecal_pkg::C400_START);
               month_in = '0;
               state_in = ST_YEAR;
            end
         end
         ST_YEAR: begin
            if (days_ff >= DAY_BITS'(ylen)) begin
               days_in = days_ff - DAY_BITS'(ylen);
               year_in = year_ff + YEAR_BITS'(1);
               c4_in   = (c4_ff == ecal_pkg::C4_W'(ecal_pkg::C4_LAST))
                       ? '0 : c4_ff + ecal_pkg::C4_W'(1);
               c100_in = (c100_ff == ecal_pkg::C100_W'(ecal_pkg::C100_LAST))
                       ? '0 : c100_ff + ecal_pkg::C100_W'(1);
               c400_in = (c400_ff == ecal_pkg::C400_W'(ecal_pkg::C400_LAST))
                       ? '0 : c400_ff + ecal_pkg::C400_W'(1);
            end else begin
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if ((month_ff == ecal_pkg::MONTH_DEC) || (days_ff < DAY_BITS'(mlen))) begin
               // december is never subtracted; what is left is the day
               out_year_in  = year_ff[ecal_pkg::YEAR_W-1:0];
               out_month_in = ecal_pkg::MONTH_W'(month_ff) + ecal_pkg::MONTH_W'(1);
               out_dom_in   = days_ff[ecal_pkg::DAY_W-1:0] + ecal_pkg::DAY_W'(1);
               out_tod_in   = tod_ff;
               state_in     = ST_OUT;
            end else begin
               days_in  = days_ff - DAY_BITS'(mlen);
               month_in = month_ff + ecal_pkg::MONTH_IDX_W'(1);
            end
         end
         ST_OUT: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      days_ff      <= days_in;
      year_ff      <= year_in;
      c4_ff        <= c4_in;
      c100_ff      <= c100_in;
      c400_ff      <= c400_in;
      month_ff     <= month_in;
      tod_ff       <= tod_in;
      out_year_ff  <= out_year_in;
      out_month_ff <= out_month_in;
      out_dom_ff   <= out_dom_in;
      out_tod_ff   <= out_tod_in;
   end

   assign pop_ready           = state_ff == ST_IDLE;
   assign rsp_ch.valid        = state_ff == ST_OUT;
   assign rsp_ch.year         = out_year_ff;
   assign rsp_ch.month        = out_month_ff;
   assign rsp_ch.day_of_month = out_dom_ff;
   assign rsp_ch.hour         = out_tod_ff.hour;
   assign rsp_ch.minute       = out_tod_ff.minute;
   assign rsp_ch.second       = out_tod_ff.second;

endmodule

// ----- design/epoch_seconds_to_calendar.sv -----
// channel   port     dir  word
// -------   ------   ---  -------------------------------------------------
// request   req_ch   in   epoch_seconds (SECONDS_BITS)
// response  rsp_ch   out  year, month, day_of_month, hour, minute, second
//
// front: reciprocal multiplies split the seconds into days, hours, minutes and
// seconds, one word at a time: accept, seven arithmetic steps, queue hand-off.
// back: a year subtraction loop, then a month loop, one word at a time; for
// most words the year loop runs longest and the back sets throughput.
// a two-word queue lets the front take the next words while the back works or
// its response waits; synchronous reset empties the queue and idles both parts.
module epoch_seconds_to_calendar #(
   parameter int SECONDS_BITS = ecal_pkg::SECONDS_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   ecal_req_if.sink   req_ch,
   ecal_rsp_if.source rsp_ch
);

   localparam int DAY_BITS   = ecal_pkg::day_bits(SECONDS_BITS);
   localparam int TOD_BITS   = $bits(ecal_pkg::tod_type);
   localparam int ENTRY_BITS = DAY_BITS + TOD_BITS;

   logic                  push_valid;
   logic                  push_ready;
   logic [DAY_BITS-1:0]   push_days;
   ecal_pkg::tod_type     push_tod;
   logic                  pop_valid;
   logic                  pop_ready;
   logic [ENTRY_BITS-1:0] pop_entry;
   logic [DAY_BITS-1:0]   pop_days;
   ecal_pkg::tod_type     pop_tod;

   // accept and split into days and time of day
   ecal_front #(
      .SECONDS_BITS (SECONDS_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_days  (push_days),
      .push_tod   (push_tod)
   );

   // queue between front and back
   ecal_fifo #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (ecal_pkg::QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_days, push_tod}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_entry)
   );

   assign pop_days = pop_entry[ENTRY_BITS-1:TOD_BITS];
   assign pop_tod  = ecal_pkg::tod_type'(pop_entry[TOD_BITS-1:0]);

   // years and months
   ecal_back #(
      .SECONDS_BITS (SECONDS_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_days  (pop_days),
      .pop_tod   (pop_tod),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ----- dv/epoch_seconds_to_calendar_tb.sv -----
module epoch_seconds_to_calendar_tb;

   localparam int SECONDS_BITS = ecal_pkg::SECONDS_BITS_DEFAULT;
   localparam int RANDOM_WORDS = 530;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 400;

   localparam int unsigned FEBRUARY = 2;
   localparam int unsigned DECEMBER = 12;

   // receiver stall patterns
   localparam int STALL_NONE      = 0;
   localparam int STALL_HALF      = 1;
   localparam int STALL_HEAVY     = 2;
   localparam int STALL_LONG_RUNS = 3;

   typedef struct packed {
      logic [ecal_pkg::YEAR_W-1:0]   year;
      logic [ecal_pkg::MONTH_W-1:0]  month;
      logic [ecal_pkg::DAY_W-1:0]    day_of_month;
      logic [ecal_pkg::HOUR_W-1:0]   hour;
      logic [ecal_pkg::MINUTE_W-1:0] minute;
      logic [ecal_pkg::SECOND_W-1:0] second;
   } calendar_word_type;

   const int unsigned common_month_days [12] = '{
      31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
   };

   logic clock;
   logic reset;

   ecal_req_if #(.SECONDS_BITS(SECONDS_BITS)) req_ch ();
   ecal_rsp_if rsp_ch ();

   epoch_seconds_to_calendar #(.SECONDS_BITS(SECONDS_BITS)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   calendar_word_type pending_dates [$];
   int                mismatch_count = 0;
   int                dates_checked  = 0;
   int                leap_days_seen = 0;
   int unsigned       min_year       = 4095;
   int unsigned       max_year       = 0;
   int                cycle_count    = 0;

   // gregorian calendar arithmetic
   function automatic bit is_leap(int unsigned y);
      if (y % 400 == 0) return 1'b1;
      if (y % 100 == 0) return 1'b0;
      return (y % 4) == 0;
   endfunction

   function automatic int unsigned days_in_year(int unsigned y);
      return is_leap(y) ? 366 : 365;
   endfunction

   function automatic int unsigned month_length(int unsigned y, int unsigned m);
      return common_month_days[m - 1] + ((m == FEBRUARY && is_leap(y)) ? 1 : 0);
   endfunction

   // seconds since the epoch for a calendar date and time of day
   function automatic longint unsigned epoch_of(int unsigned y, int unsigned m,
                                                int unsigned d, int unsigned hh,
                                                int unsigned mm, int unsigned ss);
      longint unsigned days;
      days = d - 1;
      for (int unsigned yy = ecal_pkg::EPOCH_YEAR; yy < y; yy++) days += days_in_year(yy);
      for (int unsigned mo = 1; mo < m; mo++) days += month_length(y, mo);
      return days * ecal_pkg::SECS_PER_DAY + hh * ecal_pkg::SECS_PER_HOUR
             + mm * ecal_pkg::SECS_PER_MIN + ss;
   endfunction

   // expected date and time of day for one seconds count
   function automatic calendar_word_type to_calendar(logic [SECONDS_BITS-1:0] secs);
      calendar_word_type cal;
      longint unsigned   days;
      longint unsigned   tod;
      int unsigned       yr;
      int unsigned       mon;
      days = secs / ecal_pkg::SECS_PER_DAY;
      tod  = secs % ecal_pkg::SECS_PER_DAY;
      yr   = ecal_pkg::EPOCH_YEAR;
      while (days >= days_in_year(yr)) begin
         days -= days_in_year(yr);
         yr++;
      end
      mon = 1;
      while (mon < DECEMBER && days >= month_length(yr, mon)) begin
         days -= month_length(yr, mon);
         mon++;
      end
      cal.year         = ecal_pkg::YEAR_W'(yr);
      cal.month        = ecal_pkg::MONTH_W'(mon);
      cal.day_of_month = ecal_pkg::DAY_W'(days + 1);
      cal.hour         = ecal_pkg::HOUR_W'(tod / ecal_pkg::SECS_PER_HOUR);
      cal.minute       = ecal_pkg::MINUTE_W'((tod % ecal_pkg::SECS_PER_HOUR)
                                             / ecal_pkg::SECS_PER_MIN);
      cal.second       = ecal_pkg::SECOND_W'(tod % ecal_pkg::SECS_PER_MIN);
      return cal;
   endfunction

   // random seconds count: uniform, near date boundaries, or near the ends
   function automatic logic [SECONDS_BITS-1:0] pick_epoch();
      int unsigned     sel;
      int unsigned     yy;
      int unsigned     mo;
      int unsigned     dd;
      int unsigned     hh;
      int unsigned     mm;
      int unsigned     ss;
      longint unsigned t;
      sel = $urandom_range(0, 9);
      if (sel < 4) return $urandom;
      if (sel == 8) return $urandom_range(0, 100_000_000);
      if (sel == 9) return 32'hFFFF_FFFF - $urandom_range(0, 50_000_000);
      yy = $urandom_range(ecal_pkg::EPOCH_YEAR, 2106);
      mo = $urandom_range(1, 12);
      case ($urandom_range(0, 2))
         0: dd = 1;
         1: dd = month_length(yy, mo);
         default: dd = $urandom_range(1, month_length(yy, mo));
      endcase
      case ($urandom_range(0, 2))
         0: begin
            hh = 0;  mm = 0;  ss = 0;
         end
         1: begin
            hh = 23; mm = 59; ss = 59;
         end
         default: begin
            hh = $urandom_range(0, 23);
            mm = $urandom_range(0, 59);
            ss = $urandom_range(0, 59);
         end
      endcase
      t = epoch_of(yy, mo, dd, hh, mm, ss);
      if (t > 64'hFFFF_FFFF) return $urandom;
      return SECONDS_BITS'(t);
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run limit of %0d cycles hit, %0d dates still pending",
                  $time, CYCLE_LIMIT, pending_dates.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver stall pattern
   initial begin : rsp_stall_pattern
      int mode;
      int span;
      int phase;
      rsp_ch.ready = 1'b0;
      phase = 0;
      forever begin
         mode = $urandom_range(STALL_NONE, STALL_LONG_RUNS);
         span = $urandom_range(20, 300);
         repeat (span) begin
            @(negedge clock);
            phase++;
            case (mode)
               STALL_NONE: rsp_ch.ready <= 1'b1;
               STALL_HALF: rsp_ch.ready <= 1'($urandom_range(0, 1));
               STALL_HEAVY: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ch.ready <= ((phase % 48) >= 30);
            endcase
         end
      end
   end

   task automatic report_field(string field, int unsigned want, int unsigned got);
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
   endtask

   // compare each result word with the oldest expected date
   always @(posedge clock) begin : check_dates
      calendar_word_type want;
      calendar_word_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.year         = rsp_ch.year;
         got.month        = rsp_ch.month;
         got.day_of_month = rsp_ch.day_of_month;
         got.hour         = rsp_ch.hour;
         got.minute       = rsp_ch.minute;
         got.second       = rsp_ch.second;
         if (pending_dates.size() == 0) begin
            $display("%0t: unexpected word, expected none, got %0d-%0d-%0d %0d:%0d:%0d",
                     $time, got.year, got.month, got.day_of_month,
                     got.hour, got.minute, got.second);
            mismatch_count++;
         end else begin
            want = pending_dates.pop_front();
            if (got !== want) begin
               if (got.year !== want.year)
                  report_field("year", want.year, got.year);
               if (got.month !== want.month)
                  report_field("month", want.month, got.month);
               if (got.day_of_month !== want.day_of_month)
                  report_field("day_of_month", want.day_of_month, got.day_of_month);
               if (got.hour !== want.hour)
                  report_field("hour", want.hour, got.hour);
               if (got.minute !== want.minute)
                  report_field("minute", want.minute, got.minute);
               if (got.second !== want.second)
                  report_field("second", want.second, got.second);
               mismatch_count++;
            end
            dates_checked++;
            if (want.year < min_year) min_year = want.year;
            if (want.year > max_year) max_year = want.year;
            if (want.month == FEBRUARY && want.day_of_month == 29) leap_days_seen++;
         end
      end
   end

   // drive one word and wait for it to be taken
   task automatic send_word(logic [SECONDS_BITS-1:0] secs);
      @(negedge clock);
      req_ch.valid         <= 1'b1;
      req_ch.epoch_seconds <= secs;
      do @(posedge clock); while (!req_ch.ready);
      pending_dates.push_back(to_calendar(secs));
   endtask

   task automatic send_date(int unsigned y, int unsigned m, int unsigned d,
                            int unsigned hh, int unsigned mm, int unsigned ss);
      send_word(SECONDS_BITS'(epoch_of(y, m, d, hh, mm, ss)));
   endtask

   task automatic idle_sender(int cycles);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // stop sending until every expected date has arrived
   task automatic drain_dates();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_dates.size() != 0) @(posedge clock);
   endtask

   task automatic test_time_of_day();
      send_date(1970, 1, 1, 0, 0, 0);
      send_date(1970, 1, 1, 0, 0, 59);
      send_date(1970, 1, 1, 0, 1, 0);
      send_date(1970, 1, 1, 0, 59, 59);
      send_date(1970, 1, 1, 1, 0, 0);
      send_date(1970, 1, 1, 23, 59, 59);
   endtask

   // last day of a year, first of the next, leap day of a plain leap year
   task automatic test_year_rollover();
      send_date(1970, 12, 31, 23, 59, 59);
      send_date(1971, 1, 1, 0, 0, 0);
      send_date(1972, 2, 29, 12, 0, 0);
      send_date(1972, 12, 31, 23, 59, 59);
      send_date(1973, 1, 1, 0, 0, 0);
   endtask

   // 2000 is a leap year by the 400 rule, 2100 is not by the 100 rule
   task automatic test_century_rules();
      send_date(2000, 2, 29, 0, 0, 0);
      send_date(2000, 12, 31, 23, 59, 59);
      send_date(2100, 2, 28, 23, 59, 59);
      send_date(2100, 3, 1, 0, 0, 0);
   endtask

   // month boundaries, december never subtracted
   task automatic test_month_rollover();
      send_date(2023, 2, 28, 23, 59, 59);
      send_date(2023, 3, 1, 0, 0, 0);
      send_date(2023, 11, 30, 23, 59, 59);
      send_date(2023, 12, 1, 0, 0, 0);
      send_date(2023, 12, 31, 23, 59, 59);
   endtask

   task automatic test_field_extremes();
      send_word(32'h7FFF_FFFF);
      send_word(32'h8000_0000);
      send_word(32'hFFFF_FFFF);
   endtask

   // sender holds off until the block has emptied, then resumes
   task automatic test_drain_pause();
      repeat (8) send_word(pick_epoch());
      drain_dates();
      repeat (8) send_word(pick_epoch());
   endtask

   // random words in bursts with random gaps
   task automatic test_random_words(int count);
      int burst_left;
      burst_left = $urandom_range(1, 20);
      repeat (count) begin
         send_word(pick_epoch());
         burst_left--;
         if (burst_left == 0) begin
            if ($urandom_range(0, 49) == 0)
               drain_dates();
            else if ($urandom_range(0, 2) != 0)
               idle_sender($urandom_range(1, 25));
            burst_left = $urandom_range(1, 20);
         end
      end
   endtask

   initial begin
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.epoch_seconds = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_time_of_day();
      test_year_rollover();
      test_century_rules();
      test_month_rollover();
      test_field_extremes();
      test_drain_pause();
      test_random_words(RANDOM_WORDS);

      drain_dates();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d dates from %0d to %0d, %0d of them leap days",
               dates_checked, min_year, max_year, leap_days_seen);
      $display("covered day, year and month rollovers, century leap rules and stalls");
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
